// ===== hdl/indexed_double_ended_queue_core_assert.svh =====
// ----------------------------------------------------------------------------
// indexed double-ended queue assertion macros
// shared property shapes for the queue checker
// ----------------------------------------------------------------------------
`ifndef INDEXED_DOUBLE_ENDED_QUEUE_CORE_ASSERT_SVH
`define INDEXED_DOUBLE_ENDED_QUEUE_CORE_ASSERT_SVH

// same-cycle implication, off during reset
`define IDQ_ASSERT_SAME(name, clk_i, rst_i, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (rst_i) (ante) |-> (cons)) \
    else $error("idq assertion failed");

// next-cycle implication, off during reset
`define IDQ_ASSERT_NEXT(name, clk_i, rst_i, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (rst_i) (ante) |=> (cons)) \
    else $error("idq assertion failed");

`endif

// ===== hdl/idq_pkg.sv =====
// ----------------------------------------------------------------------------
// idq_pkg
// types and codes shared by the indexed double-ended queue files
// ----------------------------------------------------------------------------
package idq_pkg;

  localparam int OP_W     = 3;
  localparam int INDEX_W  = 8;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int OCC_W    = 9;

  // operation codes
  localparam logic [OP_W-1:0] OP_PUSH_FRONT  = 3'd0;
  localparam logic [OP_W-1:0] OP_PUSH_BACK   = 3'd1;
  localparam logic [OP_W-1:0] OP_READ_INDEX  = 3'd2;
  localparam logic [OP_W-1:0] OP_WRITE_INDEX = 3'd3;
  localparam logic [OP_W-1:0] OP_READ_FRONT  = 3'd4;
  localparam logic [OP_W-1:0] OP_READ_BACK   = 3'd5;

  // result status codes
  localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_RANGE = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]    operation;
    logic [INDEX_W-1:0] index;
    logic [VALUE_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic [VALUE_W-1:0]  read_value;
    logic [STATUS_W-1:0] status;
    logic [OCC_W-1:0]    occupancy;
    logic                is_empty;
  } rsp_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_ISSUE,
    S_FINISH
  } state_t;

endpackage

// ===== hdl/idq_ram.sv =====
// ----------------------------------------------------------------------------
// idq_ram
// single-port ring store, registered read data held between reads
// ----------------------------------------------------------------------------
module idq_ram #(
  parameter int DEPTH      = 256,
  parameter int DATA_WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [DATA_WIDTH-1:0]    wdata,
  output logic [DATA_WIDTH-1:0]    rdata
);

  logic [DATA_WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en && we) begin
      mem[addr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (en && !we) begin
      rdata <= mem[addr];
    end
  end

endmodule

// ===== hdl/indexed_double_ended_queue_core.sv =====
// ----------------------------------------------------------------------------
// indexed_double_ended_queue_core
// double-ended queue in a ring store with head pointer and element count;
// push front/back, indexed read/write, front and back reads
// ----------------------------------------------------------------------------
//  channel  handshake              payload  direction
//  req      req_valid / req_stall  req_t    into block, one operation
//  rsp      rsp_valid / rsp_stall  rsp_t    out of block, one result each
//
//  an operation runs through transfer, memory access and result load
//  the registered read data of the single store port sets these steps
//  the result register frees req: a new transfer is taken while rsp stalls;
//  the result load waits only while the previous result is still held
//  rst clears head, count, state and rsp_valid; the store is not cleared
// ----------------------------------------------------------------------------
module indexed_double_ended_queue_core #(
  parameter int DEPTH      = 256,
  parameter int DATA_WIDTH = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  idq_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output idq_pkg::rsp_t rsp
);

  import idq_pkg::*;

  localparam int HW   = $clog2(DEPTH);        // ring slot bits
  localparam int CW   = $clog2(DEPTH + 1);    // count bits, holds DEPTH
  localparam int SW   = CW + 1;               // head + position sum
  localparam int CMPW = (CW > INDEX_W) ? CW : INDEX_W;

  // control state
  state_t          state, state_next;
  logic [HW-1:0]   head, head_next;
  logic [CW-1:0]   count, count_next;

  // captured operation and its outcome
  req_t                op_req;
  logic [STATUS_W-1:0] res_status, res_status_next;
  logic                rd_ok, rd_ok_next;

  // store port
  logic                  mem_en, mem_we;
  logic [HW-1:0]         mem_addr;
  logic [DATA_WIDTH-1:0] mem_wdata, mem_rdata;

  // address arithmetic
  logic [CW-1:0] pos;
  logic [SW-1:0] slot_sum;
  logic [HW-1:0] slot, head_dec;
  logic          full, empty, idx_ok;

  logic req_xfer, rsp_free, out_load;

  assign req_xfer = req_valid && !req_stall;
  assign rsp_free = !rsp_valid || !rsp_stall;

  assign full     = (count == CW'(DEPTH));
  assign empty    = (count == '0);
  assign idx_ok   = CMPW'(op_req.index) < CMPW'(count);
  assign head_dec = (head == '0) ? HW'(DEPTH - 1) : head - 1'b1;

  // logical position to ring slot, sum stays below twice the depth whenever the store is used
  always_comb begin
    case (op_req.operation)
      OP_PUSH_BACK:  pos = count;
      OP_READ_BACK:  pos = count - 1'b1;
      OP_READ_INDEX,
      OP_WRITE_INDEX: pos = CW'(op_req.index);
      default:       pos = '0;
    endcase
  end

  assign slot_sum = SW'(head) + SW'(pos);
  assign slot     = (slot_sum >= SW'(DEPTH)) ? HW'(slot_sum - SW'(DEPTH)) : HW'(slot_sum);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:   if (req_xfer) state_next = S_ISSUE;
      S_ISSUE:  state_next = S_FINISH;
      S_FINISH: if (rsp_free) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // outputs and datapath control
  always_comb begin
    req_stall       = (state != S_IDLE);
    out_load        = (state == S_FINISH) && rsp_free;
    mem_en          = 1'b0;
    mem_we          = 1'b0;
    mem_addr        = slot;
    mem_wdata       = DATA_WIDTH'(op_req.value);
    head_next       = head;
    count_next      = count;
    res_status_next = res_status;
    rd_ok_next      = rd_ok;

    if (state == S_ISSUE) begin
      res_status_next = STAT_OK;
      rd_ok_next      = 1'b0;
      case (op_req.operation)
        OP_PUSH_FRONT: begin
          if (full) begin
            res_status_next = STAT_FULL;
          end else begin
            mem_en     = 1'b1;
            mem_we     = 1'b1;
            mem_addr   = head_dec;
            head_next  = head_dec;
            count_next = count + 1'b1;
          end
        end
        OP_PUSH_BACK: begin
          if (full) begin
            res_status_next = STAT_FULL;
          end else begin
            mem_en     = 1'b1;
            mem_we     = 1'b1;
            count_next = count + 1'b1;
          end
        end
        OP_READ_INDEX: begin
          if (idx_ok) begin
            mem_en     = 1'b1;
            rd_ok_next = 1'b1;
          end else begin
            res_status_next = STAT_RANGE;
          end
        end
        OP_WRITE_INDEX: begin
          if (idx_ok) begin
            mem_en = 1'b1;
            mem_we = 1'b1;
          end else begin
            res_status_next = STAT_RANGE;
          end
        end
        OP_READ_FRONT, OP_READ_BACK: begin
          if (!empty) begin
            mem_en     = 1'b1;
            rd_ok_next = 1'b1;
          end else begin
            res_status_next = STAT_RANGE;
          end
        end
        default: begin
          // unused operation codes change nothing
          res_status_next = STAT_RANGE;
        end
      endcase
    end
  end

  // ring store
  idq_ram #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_ram (
    .clk   (clk),
    .en    (mem_en),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      head      <= '0;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      head  <= head_next;
      count <= count_next;
      if (out_load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    if (req_xfer) begin
      op_req <= req;
    end
    res_status <= res_status_next;
    rd_ok      <= rd_ok_next;
    if (out_load) begin
      rsp.read_value <= rd_ok ? VALUE_W'(mem_rdata) : '0;
      rsp.status     <= res_status;
      rsp.occupancy  <= OCC_W'(count);
      rsp.is_empty   <= (count == '0);
    end
  end

endmodule

// ===== hdl/idq_checker.sv =====
// ----------------------------------------------------------------------------
// idq_checker
// port-level checks for the indexed double-ended queue, bound to the top
// ----------------------------------------------------------------------------
`include "indexed_double_ended_queue_core_assert.svh"

module idq_checker (
  input logic          clk,
  input logic          rst,
  input logic          req_valid,
  input logic          req_stall,
  input logic          rsp_valid,
  input logic          rsp_stall,
  input idq_pkg::rsp_t rsp
);

  import idq_pkg::*;

  logic req_xfer;

  assign req_xfer = req_valid && !req_stall;

  // one operation in flight: busy right after a transfer
  `IDQ_ASSERT_NEXT(a_busy_after_xfer, clk, rst, req_xfer, req_stall)

  // empty flag agrees with occupancy
  `IDQ_ASSERT_SAME(a_empty_flag, clk, rst, rsp_valid, rsp.is_empty == (rsp.occupancy == '0))

  // failed operations read as zero
  `IDQ_ASSERT_SAME(a_err_zero, clk, rst, rsp_valid && (rsp.status != STAT_OK), rsp.read_value == '0)

  // a stalled result holds
  `IDQ_ASSERT_NEXT(a_rsp_hold, clk, rst, rsp_valid && rsp_stall, rsp_valid && $stable(rsp))

endmodule

bind indexed_double_ended_queue_core idq_checker u_idq_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_stall (req_stall),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp       (rsp)
);

// ===== tb/indexed_double_ended_queue_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_double_ended_queue_core_tb
// drives pushes, indexed reads and writes and end reads into the queue core,
// predicts each unknown result from a shadow ring, head and count, and checks
// each result transfer field by field under random idling on both sides
// ----------------------------------------------------------------------------
module indexed_double_ended_queue_core_tb;
  import idq_pkg::*;

  localparam int QUEUE_DEPTH       = 256;
  localparam int DIR_ROWS          = 20;
  localparam int RANDOM_ITEMS      = 730;
  localparam int WATCHDOG_LIMIT    = 2000;
  localparam int BACKPRESSURE_AT   = 300;
  localparam int BACKPRESSURE_HOLD = 160;
  localparam int DRAIN_CYCLES      = 10;

  // codes outside the operation set, the block must answer them as range errors
  localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;

  // one directed row: the request, and a hand-written result where known is set
  typedef struct packed {
    req_t item;
    logic known;
    rsp_t result;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst;
  logic req_valid;
  logic req_stall;
  req_t req;
  logic rsp_valid;
  logic rsp_stall;
  rsp_t rsp;

  // shadow copy of the queue contents, updated at each accepted request
  logic [VALUE_W-1:0] shadow_ring [QUEUE_DEPTH];
  logic [INDEX_W-1:0] shadow_head;
  logic [OCC_W-1:0]   shadow_count;

  rsp_t     pending_results [$];
  dir_row_t dir_rows [DIR_ROWS];
  int       failures      = 0;
  int       items_sent    = 0;
  int       results_seen  = 0;
  int       quiet_cycles  = 0;
  logic     pressure_done = 1'b0;

  always #6 clk = ~clk;

  indexed_double_ended_queue_core #(
    .DEPTH      (QUEUE_DEPTH),
    .DATA_WIDTH (VALUE_W)
  ) u_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  // idle cycles before the next transfer; the first 16 of every 64 run back to back
  function automatic int idle_draw(input int n);
    return (n % 64 < 16) ? 0 : int'($urandom_range(0, 11));
  endfunction

  // applies one operation to the shadow queue and returns the result it gives
  function automatic rsp_t queue_result_of(input req_t op);
    rsp_t               res;
    logic [INDEX_W-1:0] slot;
    logic               in_range;
    logic               full;
    res          = '0;
    res.status   = STAT_OK;
    in_range     = {1'b0, op.index} < shadow_count;
    full         = shadow_count == OCC_W'(QUEUE_DEPTH);
    case (op.operation)
      OP_PUSH_FRONT: begin
        if (full) begin
          res.status = STAT_FULL;
        end else begin
          shadow_head              = shadow_head - 1'b1;
          shadow_ring[shadow_head] = op.value;
          shadow_count             = shadow_count + 1'b1;
        end
      end
      OP_PUSH_BACK: begin
        if (full) begin
          res.status = STAT_FULL;
        end else begin
          slot              = shadow_head + shadow_count[INDEX_W-1:0];
          shadow_ring[slot] = op.value;
          shadow_count      = shadow_count + 1'b1;
        end
      end
      OP_READ_INDEX: begin
        slot = shadow_head + op.index;
        if (in_range) res.read_value = shadow_ring[slot];
        else res.status = STAT_RANGE;
      end
      OP_WRITE_INDEX: begin
        slot = shadow_head + op.index;
        if (in_range) shadow_ring[slot] = op.value;
        else res.status = STAT_RANGE;
      end
      OP_READ_FRONT: begin
        if (shadow_count != 0) res.read_value = shadow_ring[shadow_head];
        else res.status = STAT_RANGE;
      end
      OP_READ_BACK: begin
        // count of a full ring wraps to zero in the low bits, minus one lands on the tail
        slot = shadow_head + shadow_count[INDEX_W-1:0] - 1'b1;
        if (shadow_count != 0) res.read_value = shadow_ring[slot];
        else res.status = STAT_RANGE;
      end
      default: res.status = STAT_RANGE;
    endcase
    res.occupancy = shadow_count;
    res.is_empty  = shadow_count == 0;
    return res;
  endfunction

  // random request; pushes weigh enough that the ring fills about three quarters in
  function automatic req_t random_item();
    req_t op;
    int   pick;
    pick     = int'($urandom_range(0, 99));
    op.value = $urandom;
    // indexes mostly land on live elements, some go anywhere, some hit the tail
    if (shadow_count == 0 || $urandom_range(0, 9) == 0) begin
      op.index = INDEX_W'($urandom_range(0, 255));
    end else if ($urandom_range(0, 7) == 0) begin
      op.index = INDEX_W'(shadow_count - 1'b1);
    end else begin
      op.index = INDEX_W'($urandom_range(0, int'(shadow_count) - 1));
    end
    if (pick < 3) op.operation = pick[0] ? OP_SPARE_7 : OP_SPARE_6;
    else if (pick < 26) op.operation = OP_PUSH_FRONT;
    else if (pick < 49) op.operation = OP_PUSH_BACK;
    else if (pick < 64) op.operation = OP_READ_INDEX;
    else if (pick < 79) op.operation = OP_WRITE_INDEX;
    else if (pick < 90) op.operation = OP_READ_FRONT;
    else op.operation = OP_READ_BACK;
    return op;
  endfunction

  function automatic dir_row_t row_of(input logic [OP_W-1:0] o, input logic [INDEX_W-1:0] i,
                                      input logic [VALUE_W-1:0] v, input logic k,
                                      input logic [VALUE_W-1:0] rv,
                                      input logic [STATUS_W-1:0] st,
                                      input logic [OCC_W-1:0] occ, input logic emp);
    dir_row_t r;
    r.item   = '{operation: o, index: i, value: v};
    r.known  = k;
    r.result = '{read_value: rv, status: st, occupancy: occ, is_empty: emp};
    return r;
  endfunction

  // offers one request, holds it until the transfer, then records its result
  task automatic send_item(input req_t op, input logic known, input rsp_t known_result);
    int   gap;
    rsp_t predicted;
    gap = idle_draw(items_sent);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= op;
    do @(posedge clk); while (req_stall);
    // shadow state moves on every transfer, typed rows included
    predicted = queue_result_of(op);
    pending_results.insert(pending_results.size(), known ? known_result : predicted);
    items_sent++;
  endtask

  task automatic check_field(input string name, input logic [VALUE_W-1:0] want,
                             input logic [VALUE_W-1:0] got);
    if (want !== got) begin
      failures++;
      if (failures <= 10)
        $display("result %0d: %s expected %h, got %h", results_seen, name, want, got);
    end
  endtask

  // stimulus: reset, directed rows, then the random run
  initial begin
    req_valid    <= 1'b0;
    req          <= '0;
    rst          <= 1'b1;
    shadow_head  = '0;
    shadow_count = '0;
    dir_rows = '{
      // reads, writes and spare codes on the empty queue
      row_of(OP_READ_FRONT,  8'h00, 32'h0000_0000, 1'b1, '0, STAT_RANGE, 9'd0, 1'b1),
      row_of(OP_READ_BACK,   8'hff, 32'hffff_ffff, 1'b1, '0, STAT_RANGE, 9'd0, 1'b1),
      row_of(OP_READ_INDEX,  8'h00, 32'h0000_0000, 1'b1, '0, STAT_RANGE, 9'd0, 1'b1),
      row_of(OP_WRITE_INDEX, 8'hff, 32'hffff_ffff, 1'b1, '0, STAT_RANGE, 9'd0, 1'b1),
      row_of(OP_SPARE_6,     8'h55, 32'h5555_5555, 1'b1, '0, STAT_RANGE, 9'd0, 1'b1),
      row_of(OP_SPARE_7,     8'haa, 32'haaaa_aaaa, 1'b1, '0, STAT_RANGE, 9'd0, 1'b1),
      // first pushes, the front push wraps the head below zero
      row_of(OP_PUSH_BACK,   8'h00, 32'hffff_ffff, 1'b1, '0, STAT_OK, 9'd1, 1'b0),
      row_of(OP_PUSH_FRONT,  8'hff, 32'h0000_0000, 1'b1, '0, STAT_OK, 9'd2, 1'b0),
      row_of(OP_READ_FRONT,  8'h00, 32'h0000_0000, 1'b1, '0, STAT_OK, 9'd2, 1'b0),
      row_of(OP_READ_BACK,   8'h00, 32'h0000_0000, 1'b1, 32'hffff_ffff, STAT_OK, 9'd2, 1'b0),
      row_of(OP_READ_INDEX,  8'h01, 32'h0000_0000, 1'b0, '0, STAT_OK, '0, 1'b0),
      row_of(OP_WRITE_INDEX, 8'h00, 32'ha5a5_5a5a, 1'b0, '0, STAT_OK, '0, 1'b0),
      row_of(OP_READ_INDEX,  8'h00, 32'h0000_0000, 1'b0, '0, STAT_OK, '0, 1'b0),
      // index equal to the size
      row_of(OP_READ_INDEX,  8'h02, 32'h0000_0000, 1'b1, '0, STAT_RANGE, 9'd2, 1'b0),
      row_of(OP_PUSH_BACK,   8'h00, 32'h8000_0001, 1'b0, '0, STAT_OK, '0, 1'b0),
      row_of(OP_PUSH_FRONT,  8'h80, 32'h0000_0001, 1'b0, '0, STAT_OK, '0, 1'b0),
      row_of(OP_READ_INDEX,  8'hff, 32'h0000_0000, 1'b1, '0, STAT_RANGE, 9'd4, 1'b0),
      row_of(OP_WRITE_INDEX, 8'h03, 32'h1234_5678, 1'b0, '0, STAT_OK, '0, 1'b0),
      row_of(OP_READ_BACK,   8'h00, 32'h0000_0000, 1'b0, '0, STAT_OK, '0, 1'b0),
      row_of(OP_WRITE_INDEX, 8'h04, 32'hdead_beef, 1'b1, '0, STAT_RANGE, 9'd4, 1'b0)
    };
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[n]) send_item(dir_rows[n].item, dir_rows[n].known, dir_rows[n].result);
    // no pops exist, so the random run fills the ring once and then works it while full
    repeat (RANDOM_ITEMS) send_item(random_item(), 1'b0, '0);
    req_valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    // keep watching to catch any stray result
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (failures == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

  // result side: random stall before each transfer, one long hold to back up the block
  initial begin
    int   hold;
    rsp_t want;
    rsp_stall <= 1'b0;
    wait (rst === 1'b0);
    forever begin
      hold = idle_draw(results_seen);
      if (!pressure_done && results_seen >= BACKPRESSURE_AT) begin
        // sender keeps offering meanwhile, so req_stall has to rise
        hold          = BACKPRESSURE_HOLD;
        pressure_done = 1'b1;
      end
      if (hold > 0) begin
        rsp_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      rsp_stall <= 1'b0;
      do @(posedge clk); while (!rsp_valid);
      results_seen++;
      if (pending_results.size() == 0) begin
        failures++;
        if (failures <= 10) $display("result %0d arrived with nothing outstanding", results_seen);
      end else begin
        want = pending_results.pop_front();
        check_field("read_value", want.read_value, rsp.read_value);
        check_field("status", VALUE_W'(want.status), VALUE_W'(rsp.status));
        check_field("occupancy", VALUE_W'(want.occupancy), VALUE_W'(rsp.occupancy));
        check_field("is_empty", VALUE_W'(want.is_empty), VALUE_W'(rsp.is_empty));
      end
    end
  end

  // watchdog: too long without a transfer on either channel ends the run
  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule

// ===== indexed_double_ended_queue_core.f =====
+incdir+hdl
hdl/idq_pkg.sv
hdl/idq_ram.sv
hdl/indexed_double_ended_queue_core.sv
hdl/idq_checker.sv
tb/indexed_double_ended_queue_core_tb.sv
